[src/sap_pkg.sv]
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the stereo allpass phaser core.
// ----------------------------------------------------------------------------
package sap_pkg;

   // fixed field widths and scalings
   localparam int COEF_WIDTH   = 24;
   localparam int FB_WIDTH     = 16;
   localparam int MIX_WIDTH    = 17;
   localparam int STAGE_WIDTH  = 4;
   localparam int FB_FRAC      = 15;
   localparam int MIX_FRAC     = 16;
   localparam int MIX_ONE      = 65536;
   localparam int CSR_IDX_BITS = 2;

   // register reset values
   localparam logic [STAGE_WIDTH-1:0] STAGE_RESET = 4'd12;
   localparam logic [MIX_WIDTH-1:0]   MIX_RESET   = 17'd32768;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_STAGE_COUNT     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FEEDBACK_AMOUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WET_MIX         = 2'd2;

   // command codes
   localparam logic CMD_PROCESS = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   // parameter defaults
   localparam int DEF_MAX_SECTIONS  = 12;
   localparam int DEF_SAMPLE_BITS   = 24;
   localparam int DEF_COEF_FRAC_BITS = 22;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic clear;
      logic sub;
   } mac_ctrl_type;

endpackage

[src/stereo_allpass_phaser_top.sv]
// ----------------------------------------------------------------------------
// stereo_allpass_phaser_top
// Stereo phaser core: feedback, first-order allpass cascade, wet/dry mix.
// ----------------------------------------------------------------------------
// A coefficient-load word is taken while idle and leaves the core idle. After a
// sample-pair word is accepted the core is busy and takes no new word until it
// returns to idle. Each channel runs stage_count sections (none when
// stage_count is zero or above MAX_SECTIONS): feedback states, then per section
// a history read, the multiply states, a wait and a write-back, then mix states,
// all of them set by the single shared multiplier, its accumulate stage and the
// registered read of the history memory, and a final state hands the pair to
// the output register. That final state stretches for as long as the previous
// result still waits there. Once handed over, the next word is taken while the
// result is still pending. History is cleared at reset by per-entry valid
// flags, with no clearing pass.
// ----------------------------------------------------------------------------
module stereo_allpass_phaser_top #(
   parameter int MAX_SECTIONS   = sap_pkg::DEF_MAX_SECTIONS,
   parameter int SAMPLE_BITS    = sap_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = sap_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   // stream in
   input  logic req_tvalid,
   output logic req_tready,
   // left_sample, right_sample, left_a0, left_a1, left_b1,
   // right_a0, right_a1, right_b1, zero fill
   input  logic [((2*SAMPLE_BITS + 6*sap_pkg::COEF_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  logic req_tuser,
   // stream out
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // left_out, right_out, zero fill
   output logic [((2*SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // register write port
   input  logic                              csr_we,
   input  logic [sap_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sap_pkg::MIX_WIDTH-1:0]     csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int CW    = sap_pkg::COEF_WIDTH;
   localparam int AW    = SB + 1;
   localparam int BW    = CW;
   localparam int ACCW  = AW + BW + 2;
   localparam int OUT_W = ((2*SB + 7) / 8) * 8;
   localparam int DEPTH = 2 * MAX_SECTIONS;
   localparam int ADRW  = $clog2(DEPTH);
   localparam int SCW   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   localparam logic signed [ACCW-1:0] SMAX = {{(ACCW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [ACCW-1:0] SMIN = {{(ACCW-SB+1){1'b1}}, {(SB-1){1'b0}}};
   localparam logic signed [ACCW-1:0] HALF_FB  = ACCW'(1) <<< (sap_pkg::FB_FRAC - 1);
   localparam logic signed [ACCW-1:0] HALF_MIX = ACCW'(1) <<< (sap_pkg::MIX_FRAC - 1);
   localparam logic signed [ACCW-1:0] HALF_CF  = ACCW'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic [sap_pkg::MIX_WIDTH-1:0] MIX_ONE_V = sap_pkg::MIX_WIDTH'(sap_pkg::MIX_ONE);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FB   = 4'd1;
   localparam logic [3:0] S_FBW  = 4'd2;
   localparam logic [3:0] S_WET  = 4'd3;
   localparam logic [3:0] S_RD   = 4'd4;
   localparam logic [3:0] S_M0   = 4'd5;
   localparam logic [3:0] S_M1   = 4'd6;
   localparam logic [3:0] S_M2   = 4'd7;
   localparam logic [3:0] S_W1   = 4'd8;
   localparam logic [3:0] S_SEC  = 4'd9;
   localparam logic [3:0] S_MIX  = 4'd10;
   localparam logic [3:0] S_MXW  = 4'd11;
   localparam logic [3:0] S_MXO  = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;

   function automatic logic signed [SB-1:0] sat(input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] r;
      r = v;
      if (v > SMAX) begin
         r = SMAX;
      end else if (v < SMIN) begin
         r = SMIN;
      end
      return r[SB-1:0];
   endfunction

   function automatic logic signed [ACCW-1:0] ext(input logic signed [SB-1:0] v);
      return $signed({{(ACCW-SB){v[SB-1]}}, v});
   endfunction

   // registers
   logic [3:0]                     state_ff, state_in;
   logic                           chan_ff, chan_in;
   logic [SCW-1:0]                 sec_ff, sec_in;
   logic signed [SB-1:0]           dry_ff [2];
   logic signed [SB-1:0]           wet_ff, wet_in;
   logic signed [SB-1:0]           out_l_ff, out_l_in;
   logic signed [SB-1:0]           out_r_ff, out_r_in;
   logic signed [SB-1:0]           fb_ff [2];
   logic signed [CW-1:0]           a0_ff [2];
   logic signed [CW-1:0]           a1_ff [2];
   logic signed [CW-1:0]           b1_ff [2];
   logic [sap_pkg::STAGE_WIDTH-1:0] stage_count_ff;
   logic signed [sap_pkg::FB_WIDTH-1:0] famt_ff;
   logic [sap_pkg::MIX_WIDTH-1:0]  wet_mix_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                  rsp_l_ff, rsp_r_ff;

   // shared unit and history
   sap_pkg::mac_ctrl_type          mac_ctrl;
   logic signed [AW-1:0]           mac_a;
   logic signed [BW-1:0]           mac_b;
   logic signed [ACCW-1:0]         mac_acc;
   logic [ADRW-1:0]                hist_addr;
   logic                           hist_wr, hist_rd;
   logic [2*SB-1:0]                hist_rdata;
   logic signed [SB-1:0]           x1, y1, y_new, dry_cur;
   logic signed [ACCW-1:0]         rnd_fb, rnd_cf, rnd_mix;
   logic [sap_pkg::MIX_WIDTH-1:0]  mix_eff;
   logic                           no_sections, last_sec, accept, rsp_free, fb_store;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign dry_cur = dry_ff[chan_ff];
   assign x1 = $signed(hist_rdata[2*SB-1:SB]);
   assign y1 = $signed(hist_rdata[SB-1:0]);
   assign mix_eff = (wet_mix_ff > MIX_ONE_V) ? MIX_ONE_V : wet_mix_ff;
   assign no_sections = (stage_count_ff == '0) || (32'(stage_count_ff) > MAX_SECTIONS);
   assign last_sec = ((32'(sec_ff) + 32'd1) == 32'(stage_count_ff));
   assign hist_addr = ADRW'(chan_ff ? MAX_SECTIONS : 0) + ADRW'(sec_ff);

   assign rnd_fb  = (mac_acc + HALF_FB) >>> sap_pkg::FB_FRAC;
   assign rnd_cf  = (mac_acc + HALF_CF) >>> COEF_FRAC_BITS;
   assign rnd_mix = (mac_acc + HALF_MIX) >>> sap_pkg::MIX_FRAC;
   assign y_new   = sat(rnd_cf);

   // operand selection for the shared unit
   always_comb begin
      mac_ctrl = '0;
      mac_a    = '0;
      mac_b    = '0;
      hist_rd  = 1'b0;
      hist_wr  = 1'b0;
      unique case (state_ff)
         S_FB: begin
            mac_ctrl = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
            mac_a    = $signed({fb_ff[chan_ff][SB-1], fb_ff[chan_ff]});
            mac_b    = $signed({{(BW-sap_pkg::FB_WIDTH){famt_ff[sap_pkg::FB_WIDTH-1]}},
                                famt_ff});
         end
         S_RD: begin
            hist_rd = 1'b1;
         end
         S_M0: begin
            mac_ctrl = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
            mac_a    = $signed({wet_ff[SB-1], wet_ff});
            mac_b    = a0_ff[chan_ff];
         end
         S_M1: begin
            mac_ctrl = '{valid: 1'b1, clear: 1'b0, sub: 1'b0};
            mac_a    = $signed({x1[SB-1], x1});
            mac_b    = a1_ff[chan_ff];
         end
         S_M2: begin
            mac_ctrl = '{valid: 1'b1, clear: 1'b0, sub: 1'b1};
            mac_a    = $signed({y1[SB-1], y1});
            mac_b    = b1_ff[chan_ff];
         end
         S_SEC: begin
            hist_wr = 1'b1;
         end
         S_MIX: begin
            mac_ctrl = '{valid: 1'b1, clear: 1'b1, sub: 1'b0};
            mac_a    = $signed({wet_ff[SB-1], wet_ff}) - $signed({dry_cur[SB-1], dry_cur});
            mac_b    = $signed(BW'(mix_eff));
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      sec_in       = sec_ff;
      wet_in       = wet_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      fb_store     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser == sap_pkg::CMD_PROCESS) begin
               chan_in  = 1'b0;
               state_in = S_FB;
            end
         end
         S_FB:  state_in = S_FBW;
         S_FBW: state_in = S_WET;
         S_WET: begin
            wet_in   = sat(ext(dry_cur) - rnd_fb);
            sec_in   = '0;
            state_in = no_sections ? S_MIX : S_RD;
         end
         S_RD:  state_in = S_M0;
         S_M0:  state_in = S_M1;
         S_M1:  state_in = S_M2;
         S_M2:  state_in = S_W1;
         S_W1:  state_in = S_SEC;
         S_SEC: begin
            wet_in = y_new;
            if (last_sec) begin
               state_in = S_MIX;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_MIX: state_in = S_MXW;
         S_MXW: state_in = S_MXO;
         S_MXO: begin
            fb_store = 1'b1;
            if (chan_ff) begin
               out_r_in = sat(ext(dry_cur) + rnd_mix);
               state_in = S_DONE;
            end else begin
               out_l_in = sat(ext(dry_cur) + rnd_mix);
               chan_in  = 1'b1;
               state_in = S_FB;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      wet_ff   <= wet_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      sec_ff   <= sec_in;
      if (accept) begin
         dry_ff[0] <= $signed(req_tdata[SB-1:0]);
         dry_ff[1] <= $signed(req_tdata[2*SB-1:SB]);
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_l_ff <= out_l_ff;
         rsp_r_ff <= out_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chan_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fb_ff[0]       <= '0;
         fb_ff[1]       <= '0;
         a0_ff[0]       <= '0;
         a0_ff[1]       <= '0;
         a1_ff[0]       <= '0;
         a1_ff[1]       <= '0;
         b1_ff[0]       <= '0;
         b1_ff[1]       <= '0;
         stage_count_ff <= sap_pkg::STAGE_RESET;
         famt_ff        <= '0;
         wet_mix_ff     <= sap_pkg::MIX_RESET;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fb_store) begin
            fb_ff[chan_ff] <= wet_ff;
         end
         if (accept && req_tuser == sap_pkg::CMD_LOAD) begin
            a0_ff[0] <= $signed(req_tdata[2*SB + 0*CW +: CW]);
            a1_ff[0] <= $signed(req_tdata[2*SB + 1*CW +: CW]);
            b1_ff[0] <= $signed(req_tdata[2*SB + 2*CW +: CW]);
            a0_ff[1] <= $signed(req_tdata[2*SB + 3*CW +: CW]);
            a1_ff[1] <= $signed(req_tdata[2*SB + 4*CW +: CW]);
            b1_ff[1] <= $signed(req_tdata[2*SB + 5*CW +: CW]);
         end
         if (csr_we) begin
            unique case (csr_index)
               sap_pkg::REG_STAGE_COUNT:
                  stage_count_ff <= csr_wdata[sap_pkg::STAGE_WIDTH-1:0];
               sap_pkg::REG_FEEDBACK_AMOUNT:
                  famt_ff <= $signed(csr_wdata[sap_pkg::FB_WIDTH-1:0]);
               sap_pkg::REG_WET_MIX:
                  wet_mix_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   sap_mac #(
      .AW(AW),
      .BW(BW)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // history word: previous input high, previous output low
   sap_hist #(
      .DEPTH(DEPTH),
      .WIDTH(2*SB)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hist_wr),
      .wr_addr (hist_addr),
      .wr_data ({wet_ff, y_new}),
      .rd_en   (hist_rd),
      .rd_addr (hist_addr),
      .rd_data (hist_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_r_ff, rsp_l_ff});

endmodule

[src/sap_mac.sv]
// ----------------------------------------------------------------------------
// sap_mac
// Shared signed multiply-accumulate unit: registered product, then
// accumulate in the following cycle.
// ----------------------------------------------------------------------------
module sap_mac #(
   parameter int AW = 25,
   parameter int BW = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sap_pkg::mac_ctrl_type         ctrl,
   input  logic signed [AW-1:0]          op_a,
   input  logic signed [BW-1:0]          op_b,
   output logic signed [AW+BW+1:0]       acc
);

   localparam int PW   = AW + BW;
   localparam int ACCW = PW + 2;

   logic signed [PW-1:0]   prod_ff;
   sap_pkg::mac_ctrl_type  ctrl_d_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic signed [ACCW-1:0] acc_in;
   logic signed [ACCW-1:0] prod_ext;
   logic signed [ACCW-1:0] base;

   always_comb begin
      prod_ext = $signed({{2{prod_ff[PW-1]}}, prod_ff});
      base     = ctrl_d_ff.clear ? '0 : acc_ff;
      acc_in   = ctrl_d_ff.sub ? (base - prod_ext) : (base + prod_ext);
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(op_a) * PW'(op_b);
      if (ctrl_d_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (reset) begin
         ctrl_d_ff <= '0;
      end else begin
         ctrl_d_ff <= ctrl;
      end
   end

   assign acc = acc_ff;

endmodule

[src/sap_hist.sv]
// ----------------------------------------------------------------------------
// sap_hist
// Section history memory: previous input and output of every section,
// one write and one registered read a cycle, entries read as zero until
// first written after reset.
// ----------------------------------------------------------------------------
module sap_hist #(
   parameter int DEPTH = 24,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
